@@ design/b2h_pkg.sv @@
// Shared types, constants and the divider step for the BGR to HSV pixel converter.
package b2h_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned DIFF_W = CHAN_W + 1;
	// Numerators reach 360*255+255 for hue, so the remainder needs 17 bits.
	localparam int unsigned REM_W = 17;
	localparam int unsigned DVSR_W = CHAN_W + 1;
	localparam int unsigned QUO_W = CHAN_W;
	localparam int unsigned HUE_T_W = 19;

	localparam logic [QUO_W-1:0] HUE_WRAP = QUO_W'(180);
	localparam logic signed [HUE_T_W-1:0] HUE_GREEN_BASE = HUE_T_W'(120);
	localparam logic signed [HUE_T_W-1:0] HUE_BLUE_BASE = HUE_T_W'(240);
	localparam logic signed [HUE_T_W-1:0] HUE_SLOPE = HUE_T_W'(60);
	localparam logic signed [HUE_T_W-1:0] HUE_FULL = HUE_T_W'(360);

	typedef struct packed {
		logic [CHAN_W-1:0] blue_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] red_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] hue_out;
		logic [CHAN_W-1:0] sat_out;
		logic [CHAN_W-1:0] val_out;
	} pix_out_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// One restoring division in flight: partial remainder, divisor and quotient so far.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DVSR_W-1:0] dvsr;
		logic [QUO_W-1:0] quo;
	} div_t;

	typedef struct packed {
		div_t sat_div;
		div_t hue_div;
		logic sat_zero;
		logic hue_zero;
		logic [CHAN_W-1:0] val;
	} div_stage_t;

	// Two quotient bits, starting at bit hi_bit and working downwards.
	function automatic div_t div_two_bits(div_t x, int unsigned hi_bit);
		div_t y;
		logic [REM_W-1:0] shifted;
		y = x;
		for (int unsigned j = 0; j < 2; j++) begin
			shifted = REM_W'(y.dvsr) << (hi_bit - j);
			if (y.rem >= shifted) begin
				y.rem = y.rem - shifted;
				y.quo = {y.quo[QUO_W-2:0], 1'b1};
			end else begin
				y.quo = {y.quo[QUO_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

endpackage

@@ design/bgr_to_hsv_pixel.sv @@
// Pipelined BGR to HSV conversion, one pixel per clock unless hsv_ready stalls it.
//
// Pixels enter on pix with pix_valid and pix_ready; results leave on hsv with
// hsv_valid and hsv_ready. A beat moves on a channel at a rising edge with
// valid and ready both high. Each pixel yields exactly one result beat.
// The input beat is registered in stage one, and its result passes through
// stages two to seven; hsv_valid is the stage seven valid bit. Throughput is
// one pixel per cycle while hsv_ready holds high: every stage is a register,
// and restoring dividers for saturation and hue span four stages, two quotient
// bits per stage. Stage one finds maximum, minimum and sector; stage two
// forms the numerators; stages three to six divide; stage seven applies the
// hue wrap and the grey and black cases and is the output register.
// Reset clears all valid bits, so the pipeline comes up empty.
// When hsv_ready is low, a full stage holds while the stage after it holds,
// and pix_ready falls once the whole pipeline is full; no beat is lost
// or repeated.
module bgr_to_hsv_pixel (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_ready,
	input  b2h_pkg::pix_in_t pix,
	output logic hsv_valid,
	input  logic hsv_ready,
	output b2h_pkg::pix_out_t hsv
);

	localparam int unsigned CW = b2h_pkg::CHAN_W;
	localparam int unsigned TW = b2h_pkg::HUE_T_W;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7 = !valid_s7 || hsv_ready;
	assign en_s6 = !valid_s6 || en_s7;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign pix_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= pix_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
		end
	end

	// Stage one: maximum, minimum and the sector of the largest channel.
	logic [CW-1:0] mx_c, mn_c;
	logic signed [b2h_pkg::DIFF_W-1:0] diff_c;
	b2h_pkg::sector_t sec_c;

	always_comb begin
		if (pix.red_in >= pix.green_in && pix.red_in >= pix.blue_in) begin
			sec_c = b2h_pkg::SEC_RED;
			mx_c = pix.red_in;
			diff_c = signed'({1'b0, pix.green_in}) - signed'({1'b0, pix.blue_in});
		end else if (pix.green_in >= pix.blue_in) begin
			sec_c = b2h_pkg::SEC_GREEN;
			mx_c = pix.green_in;
			diff_c = signed'({1'b0, pix.blue_in}) - signed'({1'b0, pix.red_in});
		end else begin
			sec_c = b2h_pkg::SEC_BLUE;
			mx_c = pix.blue_in;
			diff_c = signed'({1'b0, pix.red_in}) - signed'({1'b0, pix.green_in});
		end
		mn_c = pix.red_in;
		if (pix.green_in < mn_c) mn_c = pix.green_in;
		if (pix.blue_in < mn_c) mn_c = pix.blue_in;
	end

	logic [CW-1:0] mx_s1, d_s1;
	logic signed [b2h_pkg::DIFF_W-1:0] diff_s1;
	b2h_pkg::sector_t sec_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1 <= mx_c;
			d_s1 <= mx_c - mn_c;
			diff_s1 <= diff_c;
			sec_s1 <= sec_c;
		end
	end

	// Stage two: hue scaled by delta, wrapped to be non-negative, and both numerators.
	logic signed [TW-1:0] d_t, diff_t, base_c, t_c, t_wrap_c;
	logic [b2h_pkg::REM_W-1:0] sat_num_c, hue_num_c;

	always_comb begin
		d_t = signed'({{(TW - CW){1'b0}}, d_s1});
		diff_t = TW'(diff_s1);
		unique case (sec_s1)
			b2h_pkg::SEC_RED: base_c = '0;
			b2h_pkg::SEC_GREEN: base_c = TW'(b2h_pkg::HUE_GREEN_BASE * d_t);
			b2h_pkg::SEC_BLUE: base_c = TW'(b2h_pkg::HUE_BLUE_BASE * d_t);
			default: base_c = '0;
		endcase
		t_c = base_c + TW'(b2h_pkg::HUE_SLOPE * diff_t);
		if (t_c < 0)
			t_wrap_c = t_c + TW'(b2h_pkg::HUE_FULL * d_t);
		else
			t_wrap_c = t_c;
		hue_num_c = b2h_pkg::REM_W'(t_wrap_c + d_t);
		// 255*d is d*256 - d; half the maximum gives round to nearest.
		sat_num_c = ({1'b0, d_s1, 8'b0} - b2h_pkg::REM_W'(d_s1))
			+ b2h_pkg::REM_W'(mx_s1 >> 1);
	end

	b2h_pkg::div_stage_t dv_s2, dv_s3, dv_s4, dv_s5, dv_s6;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dv_s2.sat_div.rem <= sat_num_c;
			dv_s2.sat_div.dvsr <= b2h_pkg::DVSR_W'(mx_s1);
			dv_s2.sat_div.quo <= '0;
			dv_s2.hue_div.rem <= hue_num_c;
			dv_s2.hue_div.dvsr <= {d_s1, 1'b0};
			dv_s2.hue_div.quo <= '0;
			dv_s2.sat_zero <= (mx_s1 == '0);
			dv_s2.hue_zero <= (d_s1 == '0);
			dv_s2.val <= mx_s1;
		end
	end

	// Stages three to six: two quotient bits per stage for both divisions.
	function automatic b2h_pkg::div_stage_t step(b2h_pkg::div_stage_t x,
			int unsigned hi_bit);
		b2h_pkg::div_stage_t y;
		y = x;
		y.sat_div = b2h_pkg::div_two_bits(x.sat_div, hi_bit);
		y.hue_div = b2h_pkg::div_two_bits(x.hue_div, hi_bit);
		return y;
	endfunction

	always_ff @(posedge clk) begin
		if (en_s3) dv_s3 <= step(dv_s2, 7);
		if (en_s4) dv_s4 <= step(dv_s3, 5);
		if (en_s5) dv_s5 <= step(dv_s4, 3);
		if (en_s6) dv_s6 <= step(dv_s5, 1);
	end

	// Stage seven: a hue of exactly 180 wraps to 0; black and grey force zeros.
	b2h_pkg::pix_out_t out_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			out_s7.val_out <= dv_s6.val;
			out_s7.sat_out <= dv_s6.sat_zero ? '0 : dv_s6.sat_div.quo;
			if (dv_s6.hue_zero || dv_s6.hue_div.quo >= b2h_pkg::HUE_WRAP)
				out_s7.hue_out <= '0;
			else
				out_s7.hue_out <= dv_s6.hue_div.quo;
		end
	end

	assign hsv_valid = valid_s7;
	assign hsv = out_s7;

endmodule
